FILE: hw/rtl/g3d_pkg.sv
// Package for the 3D grid depth-first path search block.
// Holds the sequencer state type, action codes, stream word types and fixed constants; no dependencies.
package g3d_pkg;

  localparam int unsigned MOVE_COUNT = 27;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_SRCH  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_TOP,
    ST_TOPW,
    ST_MOVE,
    ST_PROBE,
    ST_CHECK,
    ST_RDW,
    ST_RDW2,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] cell_x;
    logic [2:0] cell_y;
    logic [2:0] cell_z;
    logic       blocked;
    logic [8:0] path_index;
  } in_word_t;

  typedef struct packed {
    logic       found;
    logic [9:0] path_length;
    logic [2:0] pos_x;
    logic [2:0] pos_y;
    logic [2:0] pos_z;
  } out_word_t;

endpackage

FILE: hw/rtl/g3d_stream_if.sv
// Valid/ready channel interface carrying one word of type T.
// Has no dependencies of its own; the testbench sets T to the g3d_pkg word types.
interface g3d_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/grid3d_dfs_path_search_top.sv
// Top level of the 3D grid depth-first path search.
// Depends on g3d_pkg and g3d_stream_if.
//
//   channel   dir  payload                                         handshake
//   in_ch     in   action, cell_x/y/z, blocked, path_index        valid/ready
//   out_ch    out  found, path_length, pos_x/y/z                  valid/ready
//   cfg       in   grid_size (cfg_we, cfg_data)                   write enable
//
// A load stays in ST_IDLE; a read passes ST_RDW, ST_RDW2 and ST_OUT. A search
// clears the visited map entry by entry (2**(3*clog2(GRID_EDGE_MAX)), 512 at
// the default), reloads the stack top in ST_TOP/ST_TOPW, skips moves leaving
// the cube in ST_MOVE, probes the rest through the shared move evaluator in
// ST_MOVE, ST_PROBE and ST_CHECK, pops in ST_MOVE and ends in ST_OUT. rst clears
// the control state and sets grid_size to 8. A new word is taken while a result
// waits; a further result holds in ST_OUT until the waiting one is taken.
module grid3d_dfs_path_search_top #(
  parameter int unsigned GRID_EDGE_MAX = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [3:0] cfg_data,
  g3d_stream_if.sink   in_ch,
  g3d_stream_if.source out_ch
);
  import g3d_pkg::*;

  localparam int unsigned CW = $clog2(GRID_EDGE_MAX);
  localparam int unsigned AW = 3 * CW;
  localparam int unsigned CELLS = 1 << AW;
  localparam int unsigned DW = AW + 1;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic [4:0]    mv;
  } ent_t;

  // memories
  logic   wall_mem [CELLS];
  logic   seen_mem [CELLS];
  ent_t   stk_mem  [CELLS];

  state_t state, state_next;
  logic [3:0] grid_size;
  logic [CW:0] edge_s;
  logic [DW-1:0] depth;
  logic found;
  logic [AW:0] clr_cnt;
  ent_t top;
  logic [CW+1:0] nx, ny, nz;
  logic [AW-1:0] naddr;
  logic wall_rd, seen_rd;
  ent_t stk_rd;
  logic [1:0] act;
  logic [8:0] ridx;
  out_word_t out_reg;
  logic out_v;

  // clamp edge length
  always_comb begin
    if (grid_size == 4'd0) edge_s = (CW+1)'(1);
    else if (32'(grid_size) > GRID_EDGE_MAX) edge_s = (CW+1)'(GRID_EDGE_MAX);
    else edge_s = (CW+1)'(grid_size);
  end

  // shared move evaluator: split move number into offsets, candidate coordinates
  logic [1:0] dx, dy, dz;
  logic [4:0] rem9;
  always_comb begin
    if (top.mv >= 5'd18) begin
      dx = 2'd2;
      rem9 = top.mv - 5'd18;
    end else if (top.mv >= 5'd9) begin
      dx = 2'd1;
      rem9 = top.mv - 5'd9;
    end else begin
      dx = 2'd0;
      rem9 = top.mv;
    end
    if (rem9 >= 5'd6) begin
      dy = 2'd2;
      dz = 2'(rem9 - 5'd6);
    end else if (rem9 >= 5'd3) begin
      dy = 2'd1;
      dz = 2'(rem9 - 5'd3);
    end else begin
      dy = 2'd0;
      dz = 2'(rem9);
    end
    nx = {2'b0, top.x} + (CW+2)'(dx) - (CW+2)'(1);
    ny = {2'b0, top.y} + (CW+2)'(dy) - (CW+2)'(1);
    nz = {2'b0, top.z} + (CW+2)'(dz) - (CW+2)'(1);
    naddr = {nx[CW-1:0], ny[CW-1:0], nz[CW-1:0]};
  end

  logic cand_ok;
  assign cand_ok = (nx < (CW+2)'(edge_s)) && (ny < (CW+2)'(edge_s)) &&
                   (nz < (CW+2)'(edge_s));
  logic at_goal;
  assign at_goal = ({1'b0, top.x} == edge_s - 1'b1) &&
                   ({1'b0, top.y} == edge_s - 1'b1) &&
                   ({1'b0, top.z} == edge_s - 1'b1);

  logic in_range;
  assign in_range = (32'(in_ch.data.cell_x) < GRID_EDGE_MAX) &&
                    (32'(in_ch.data.cell_y) < GRID_EDGE_MAX) &&
                    (32'(in_ch.data.cell_z) < GRID_EDGE_MAX);

  assign in_ch.ready = (state == ST_IDLE);

  // load the output register once the previous word has left
  logic out_load;
  assign out_load = (state == ST_OUT) && (!out_v || out_ch.ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          case (in_ch.data.action)
            ACT_SRCH: state_next = ST_CLEAR;
            ACT_READ: state_next = ST_RDW;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_cnt == (AW+1)'(CELLS - 1)) begin
          state_next = (edge_s == (CW+1)'(1)) ? ST_OUT : ST_TOP;
        end
      end
      ST_TOP:   state_next = (depth == '0) ? ST_OUT : ST_TOPW;
      ST_TOPW:  state_next = ST_MOVE;
      ST_MOVE: begin
        if (at_goal) state_next = ST_OUT;
        else if (top.mv >= 5'(MOVE_COUNT)) state_next = ST_TOP;
        else if (!cand_ok) state_next = ST_MOVE;
        else state_next = ST_PROBE;
      end
      ST_PROBE: state_next = ST_CHECK;
      ST_CHECK: state_next = ST_MOVE;
      ST_RDW:   state_next = ST_RDW2;
      ST_RDW2:  state_next = ST_OUT;
      ST_OUT:   state_next = out_load ? ST_IDLE : ST_OUT;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // control registers
  logic push;
  assign push = (state == ST_CHECK) && !wall_rd && !seen_rd &&
                (32'(depth) < CELLS);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= 4'd8;
      depth <= '0;
      found <= 1'b0;
      out_v <= 1'b0;
      clr_cnt <= '0;
    end else begin
      if (cfg_we) grid_size <= cfg_data;
      if (out_load) out_v <= 1'b1;
      else if (out_v && out_ch.ready) out_v <= 1'b0;
      case (state)
        ST_IDLE: begin
          clr_cnt <= '0;
          if (in_ch.valid && in_ch.ready && in_ch.data.action == ACT_SRCH) begin
            depth <= '0;
            found <= 1'b0;
          end
        end
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(CELLS - 1)) begin
            if (edge_s == (CW+1)'(1)) found <= 1'b1;
            else depth <= DW'(1);
          end
        end
        ST_MOVE: begin
          if (at_goal) found <= 1'b1;
          else if (top.mv >= 5'(MOVE_COUNT)) depth <= depth - 1'b1;
        end
        ST_CHECK: if (push) depth <= depth + 1'b1;
        default: ;
      endcase
    end
  end

  // working copy of the stack top and input capture; hold the move number
  // through the probe so the checked cell matches the tried move
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_ch.valid && in_ch.ready) begin
      act <= in_ch.data.action;
      ridx <= in_ch.data.path_index;
    end
    if (state == ST_TOPW) top <= stk_rd;
    else if (state == ST_MOVE && !at_goal && top.mv < 5'(MOVE_COUNT) && !cand_ok)
      top.mv <= top.mv + 1'b1;
    else if (push) top <= '{x: naddr[AW-1 -: CW], y: naddr[2*CW-1 -: CW],
                             z: naddr[CW-1:0], mv: 5'd0};
    else if (state == ST_CHECK) top.mv <= top.mv + 1'b1;
  end

  // wall memory
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_ch.valid && in_ch.ready &&
        in_ch.data.action == ACT_LOAD && in_range)
      wall_mem[{CW'(in_ch.data.cell_x), CW'(in_ch.data.cell_y),
                CW'(in_ch.data.cell_z)}] <= in_ch.data.blocked;
    wall_rd <= wall_mem[naddr];
  end

  // visited memory
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) seen_mem[clr_cnt[AW-1:0]] <= (clr_cnt == '0);
    else if (push) seen_mem[naddr] <= 1'b1;
    seen_rd <= seen_mem[naddr];
  end

  // stack memory: one write, one read port
  logic [AW-1:0] stk_raddr;
  logic [DW-1:0] len;
  assign len = found ? depth : '0;
  always_comb begin
    if (state inside {ST_RDW, ST_RDW2, ST_OUT}) stk_raddr = AW'(ridx);
    else stk_raddr = AW'(depth - 1'b1);
  end
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR && clr_cnt == '0) stk_mem[0] <= '0;
    else if (state == ST_MOVE) stk_mem[AW'(depth - 1'b1)] <= top;
    else if (push) stk_mem[AW'(depth)] <= '{x: naddr[AW-1 -: CW],
                    y: naddr[2*CW-1 -: CW], z: naddr[CW-1:0], mv: 5'd0};
    stk_rd <= stk_mem[stk_raddr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reg.found <= found;
      out_reg.path_length <= 10'(len);
      out_reg.pos_x <= '0;
      out_reg.pos_y <= '0;
      out_reg.pos_z <= '0;
      if (act == ACT_READ && 32'(ridx) < 32'(len)) begin
        out_reg.pos_x <= 3'(stk_rd.x);
        out_reg.pos_y <= 3'(stk_rd.y);
        out_reg.pos_z <= 3'(stk_rd.z);
      end
    end
  end

  assign out_ch.valid = out_v;
  assign out_ch.data = out_reg;

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_found_len: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.data.found |-> out_ch.data.path_length == 10'd0)
    else $error("length without path");
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    32'(depth) <= CELLS) else $error("stack overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_v && !out_ch.ready |=> out_v) else $error("result dropped");

endmodule

FILE: tb/sv/grid3d_dfs_path_search_top_tb.sv
// Testbench for the 3D grid depth-first path search block.
// Checks search and read words against a behavioral path search model.
// Depends on g3d_pkg, g3d_stream_if and grid3d_dfs_path_search_top.
module grid3d_dfs_path_search_top_tb;
  import g3d_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EDGE_MAX = 8;
  localparam int CELLS = EDGE_MAX * EDGE_MAX * EDGE_MAX;
  localparam longint CYCLE_LIMIT = 20000000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [3:0] cfg_data;

  g3d_stream_if #(.T(in_word_t)) in_ch ();
  g3d_stream_if #(.T(out_word_t)) out_ch ();

  grid3d_dfs_path_search_top #(.GRID_EDGE_MAX(EDGE_MAX)) u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // model state
  bit wall_bits[CELLS];
  bit seen_bits[CELLS];
  logic [2:0] trail_x[CELLS];
  logic [2:0] trail_y[CELLS];
  logic [2:0] trail_z[CELLS];
  int trail_next[CELLS];
  int trail_depth;
  bit path_found;
  int edge_reg;

  out_word_t expected_q[$];
  int errors;
  int send_idle_pct;
  int recv_stall_pct;
  longint cycles;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("ERROR t=%0t %s", $realtime, what);
    errors++;
  endtask

  function automatic int addr_of(int x, int y, int z);
    return (x * EDGE_MAX + y) * EDGE_MAX + z;
  endfunction

  // walk the cube depth first with an explicit stack
  function automatic void search_path();
    int s;
    int m;
    int nx;
    int ny;
    int nz;
    int t;
    s = (edge_reg == 0) ? 1 : (edge_reg > EDGE_MAX ? EDGE_MAX : edge_reg);
    foreach (seen_bits[i]) seen_bits[i] = 0;
    trail_depth = 0;
    path_found = 0;
    if (s == 1) begin
      path_found = 1;
      return;
    end
    trail_x[0] = 0; trail_y[0] = 0; trail_z[0] = 0; trail_next[0] = 0;
    seen_bits[0] = 1;
    trail_depth = 1;
    while (trail_depth > 0) begin
      t = trail_depth - 1;
      if (trail_x[t] == s - 1 && trail_y[t] == s - 1 && trail_z[t] == s - 1) begin
        path_found = 1;
        return;
      end
      if (trail_next[t] >= MOVE_COUNT) begin
        trail_depth--;
        continue;
      end
      m = trail_next[t];
      trail_next[t] = m + 1;
      nx = int'(trail_x[t]) + m / 9 - 1;
      ny = int'(trail_y[t]) + (m / 3) % 3 - 1;
      nz = int'(trail_z[t]) + m % 3 - 1;
      if (nx < 0 || ny < 0 || nz < 0 || nx >= s || ny >= s || nz >= s) continue;
      if (wall_bits[addr_of(nx, ny, nz)] || seen_bits[addr_of(nx, ny, nz)]) continue;
      if (trail_depth >= CELLS) continue;
      seen_bits[addr_of(nx, ny, nz)] = 1;
      trail_x[trail_depth] = 3'(nx); trail_y[trail_depth] = 3'(ny);
      trail_z[trail_depth] = 3'(nz); trail_next[trail_depth] = 0;
      trail_depth++;
    end
  endfunction

  function automatic void predict_word(in_word_t w);
    out_word_t r;
    int len;
    if (w.action == ACT_LOAD) begin
      wall_bits[addr_of(int'(w.cell_x), int'(w.cell_y), int'(w.cell_z))] = w.blocked;
      return;
    end
    if (w.action == ACT_NONE) return;
    if (w.action == ACT_SRCH) search_path();
    len = path_found ? trail_depth : 0;
    r = '0;
    r.found = path_found;
    r.path_length = 10'(len);
    if (w.action == ACT_READ && int'(w.path_index) < len) begin
      r.pos_x = trail_x[w.path_index];
      r.pos_y = trail_y[w.path_index];
      r.pos_z = trail_z[w.path_index];
    end
    expected_q.push_back(r);
  endfunction

  // receiver: random stall, compare each accepted word
  always @(posedge clk) begin
    out_word_t e;
    if (rst) begin
      out_ch.ready <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result word");
        end else begin
          e = expected_q.pop_front();
          if (out_ch.data.found !== e.found)
            report_mismatch($sformatf("found %0b exp %0b", out_ch.data.found, e.found));
          if (out_ch.data.path_length !== e.path_length)
            report_mismatch($sformatf("path_length %0d exp %0d",
                                      out_ch.data.path_length, e.path_length));
          if (out_ch.data.pos_x !== e.pos_x || out_ch.data.pos_y !== e.pos_y ||
              out_ch.data.pos_z !== e.pos_z)
            report_mismatch($sformatf("pos %0d,%0d,%0d exp %0d,%0d,%0d",
                                      out_ch.data.pos_x, out_ch.data.pos_y,
                                      out_ch.data.pos_z, e.pos_x, e.pos_y, e.pos_z));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // send one word, with a random idle gap first; valid stays high after accept
  // until the next word, an idle gap or a drain
  task automatic send_word(in_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_word(w);
  endtask

  task automatic load_cell(int x, int y, int z, bit b);
    in_word_t w;
    w = '0;
    w.action = ACT_LOAD; w.cell_x = 3'(x); w.cell_y = 3'(y); w.cell_z = 3'(z);
    w.blocked = b;
    send_word(w);
  endtask

  task automatic run_search();
    in_word_t w;
    w = $bits(in_word_t)'($urandom);
    w.action = ACT_SRCH;
    send_word(w);
  endtask

  task automatic read_entry(int idx);
    in_word_t w;
    w = $bits(in_word_t)'($urandom);
    w.action = ACT_READ;
    w.path_index = 9'(idx);
    send_word(w);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_edge(int s);
    drain();
    cfg_we <= 1;
    cfg_data <= 4'(s);
    @(posedge clk);
    cfg_we <= 0;
    edge_reg = s;
  endtask

  // fill the whole storage so no unwritten cell is ever read
  task automatic fill_cube(int wall_pct);
    for (int x = 0; x < EDGE_MAX; x++)
      for (int y = 0; y < EDGE_MAX; y++)
        for (int z = 0; z < EDGE_MAX; z++)
          load_cell(x, y, z, $urandom_range(99) < wall_pct);
  endtask

  // directed corner cases
  task automatic test_directed();
    set_edge(1);
    read_entry(0);
    run_search();
    read_entry(0);
    set_edge(2);
    load_cell(1, 1, 1, 0);
    load_cell(0, 0, 0, 1);
    run_search();
    read_entry(0);
    read_entry(1);
    read_entry(2);
    read_entry(511);
    load_cell(1, 1, 1, 1);
    run_search();
    read_entry(0);
    begin
      in_word_t w;
      w = '1;
      send_word(w);
    end
    set_edge(0);
    run_search();
    set_edge(15);
    run_search();
    read_entry(1);
  endtask

  // random cubes: a search, then reads at random indices in and beyond the path
  task automatic test_random_paths(int rounds);
    int s;
    int len;
    for (int r = 0; r < rounds; r++) begin
      s = $urandom_range(2, 4);
      if ($urandom_range(9) == 0) s = $urandom_range(5, EDGE_MAX);
      set_edge(s);
      for (int k = 0; k < 6; k++)
        load_cell($urandom_range(s - 1), $urandom_range(s - 1), $urandom_range(s - 1),
                  $urandom_range(99) < 30);
      run_search();
      len = path_found ? trail_depth : 0;
      for (int k = 0; k < 3; k++)
        read_entry($urandom_range(99) < 85 ? $urandom_range(len + 1) : $urandom_range(511));
      if ($urandom_range(9) == 0) begin
        in_word_t w;
        w = $bits(in_word_t)'($urandom);
        send_word(w);
      end
    end
  endtask

  task automatic test_phase(int idle, int stall, int rounds);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    test_random_paths(rounds);
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_data = 0;
    in_ch.valid = 0;
    in_ch.data = '0;
    errors = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    edge_reg = 8;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    fill_cube(10);
    test_directed();
    test_phase(0, 0, 20);
    test_phase(47, 0, 20);
    drain();
    test_phase(0, 47, 20);
    test_phase(38, 38, 20);
    set_edge(EDGE_MAX);
    test_phase(0, 0, 5);
    drain();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

FILE: grid3d_dfs_path_search_top.f
hw/rtl/g3d_pkg.sv
hw/rtl/g3d_stream_if.sv
hw/rtl/grid3d_dfs_path_search_top.sv
tb/sv/grid3d_dfs_path_search_top_tb.sv
